[src/i2cbm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants for the I2C byte command master: command codes,
// configuration register indexes and the structs passed between modules.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

	localparam int unsigned BITS_PER_BYTE = 8;
	localparam int unsigned BIT_CNT_W     = 4;
	localparam int unsigned CFG_DATA_W    = 16;
	localparam int unsigned CFG_INDEX_W   = 2;

	// command codes
	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_START     = 3'd1;
	localparam logic [2:0] OP_WRITE     = 3'd2;
	localparam logic [2:0] OP_READ_ACK  = 3'd3;
	localparam logic [2:0] OP_READ_NACK = 3'd4;
	localparam logic [2:0] OP_STOP      = 3'd5;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_DELAY = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_POLL_LIMIT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RX_SETTLE  = 2'd2;

	// configuration reset values
	localparam logic [15:0] HALF_DELAY_RST = 16'd5;
	localparam logic [7:0]  POLL_LIMIT_RST = 8'd50;
	localparam logic [15:0] RX_SETTLE_RST  = 16'd25;

	typedef struct packed {
		logic [15:0] half_delay_ticks;
		logic [7:0]  ack_poll_limit;
		logic [15:0] rx_settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic       scl_high;
		logic       sda_low;
		logic       busy_res;
		logic       done_res;
		logic       ack_ok;
		logic [7:0] rd_byte;
	} res_t;

endpackage

[src/i2c_byte_command_master.sv]
// ----------------------------------------------------------------------------
// i2c_byte_command_master
// I2C master driven by byte commands, one timebase tick per request.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  op, wr_byte, sda_in
//   output    out        out_valid/out_stall  scl_high, sda_low, busy_res,
//                                             done_res, ack_ok, rd_byte
//   config    in         cfg_wr_en            cfg_index, cfg_data
//
// One request per cycle while in_stall is low; each request gives one result,
// passing the input register, then sequencer logic into the result register.
// Reset is asynchronous: sequencer idle with bus released, config at defaults.
// A stalled result holds in the result register; the input register takes
// a new request as long as the result register is free or being drained.
// ----------------------------------------------------------------------------
module i2c_byte_command_master (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         op,
	input  logic [7:0]                         wr_byte,
	input  logic                               sda_in,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               scl_high,
	output logic                               sda_low,
	output logic                               busy_res,
	output logic                               done_res,
	output logic                               ack_ok,
	output logic [7:0]                         rd_byte,
	input  logic                               cfg_wr_en,
	input  logic [i2cbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [i2cbm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic            valid_s1;
	logic [2:0]      op_s1;
	logic [7:0]      wr_byte_s1;
	logic            sda_in_s1;
	logic            adv;
	i2cbm_pkg::cfg_t cfg;
	i2cbm_pkg::res_t res;
	i2cbm_pkg::res_t res_s2;

	// request moves on when the result register is free or drains
	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1      <= op;
			wr_byte_s1 <= wr_byte;
			sda_in_s1  <= sda_in;
		end
	end

	i2cbm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	i2cbm_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.op      (op_s1),
		.wr_byte (wr_byte_s1),
		.sda_in  (sda_in_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign scl_high = res_s2.scl_high;
	assign sda_low  = res_s2.sda_low;
	assign busy_res = res_s2.busy_res;
	assign done_res = res_s2.done_res;
	assign ack_ok   = res_s2.ack_ok;
	assign rd_byte  = res_s2.rd_byte;

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	a_ack_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ack_ok |-> done_res)
		else $error("ack reported without done");

	a_rd_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (rd_byte != 8'd0) |-> done_res)
		else $error("read byte shown without done");

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("advanced request lost before result register");

endmodule

[src/i2cbm_cfg.sv]
// ----------------------------------------------------------------------------
// i2cbm_cfg
// Configuration register file: bus timing and ACK poll settings.
// ----------------------------------------------------------------------------
module i2cbm_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [i2cbm_pkg::CFG_INDEX_W-1:0]  index,
	input  logic [i2cbm_pkg::CFG_DATA_W-1:0]   data,
	output i2cbm_pkg::cfg_t                    cfg
);

	i2cbm_pkg::cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_delay_ticks <= i2cbm_pkg::HALF_DELAY_RST;
			cfg_q.ack_poll_limit   <= i2cbm_pkg::POLL_LIMIT_RST;
			cfg_q.rx_settle_ticks  <= i2cbm_pkg::RX_SETTLE_RST;
		end else if (wr_en) begin
			unique case (index)
				i2cbm_pkg::CFG_HALF_DELAY: cfg_q.half_delay_ticks <= data;
				i2cbm_pkg::CFG_POLL_LIMIT: cfg_q.ack_poll_limit   <= data[7:0];
				i2cbm_pkg::CFG_RX_SETTLE:  cfg_q.rx_settle_ticks  <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/i2cbm_seq.sv]
// ----------------------------------------------------------------------------
// i2cbm_seq
// Bus segment sequencer: holds the command state and works out the next
// state and the pin/result values for one timebase tick.
// ----------------------------------------------------------------------------
module i2cbm_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [2:0]      op,
	input  logic [7:0]      wr_byte,
	input  logic            sda_in,
	input  i2cbm_pkg::cfg_t cfg,
	output i2cbm_pkg::res_t res
);

	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_ST0  = 5'd1,
		PH_ST1  = 5'd2,
		PH_ST2  = 5'd3,
		PH_SP0  = 5'd4,
		PH_SP1  = 5'd5,
		PH_SP2  = 5'd6,
		PH_WB   = 5'd7,
		PH_W1   = 5'd8,
		PH_W2   = 5'd9,
		PH_W3   = 5'd10,
		PH_A0   = 5'd11,
		PH_A1   = 5'd12,
		PH_A2   = 5'd13,
		PH_A3   = 5'd14,
		PH_A4   = 5'd15,
		PH_R0   = 5'd16,
		PH_R1   = 5'd17,
		PH_R2   = 5'd18,
		PH_R3   = 5'd19,
		PH_K0   = 5'd20,
		PH_K1   = 5'd21,
		PH_K2   = 5'd22,
		PH_K3   = 5'd23,
		PH_N0   = 5'd24,
		PH_N1   = 5'd25,
		PH_N2   = 5'd26,
		PH_FIN  = 5'd31
	} phase_t;

	phase_t                             phase_q, n_phase, tgt;
	logic [15:0]                        delay_q, n_delay;
	logic                               second_q, n_second;
	logic [i2cbm_pkg::BIT_CNT_W-1:0]    bit_q, n_bit;
	logic [7:0]                         shift_q, n_shift;
	logic [7:0]                         poll_q, n_poll, poll_dec;
	logic [2:0]                         op_q, n_op;
	logic                               scl_q, n_scl;
	logic                               sda_low_q, n_sda;
	logic                               ack_q, n_ack;
	logic                               n_done;
	logic                               go;
	logic [15:0]                        half;

	// a zero half delay behaves as one tick
	assign half     = (cfg.half_delay_ticks == 16'd0) ? 16'd1 : cfg.half_delay_ticks;
	assign poll_dec = poll_q - 8'd1;

	// next state for one tick
	always_comb begin
		n_phase  = phase_q;
		n_delay  = delay_q;
		n_second = second_q;
		n_bit    = bit_q;
		n_shift  = shift_q;
		n_poll   = poll_q;
		n_op     = op_q;
		n_scl    = scl_q;
		n_sda    = sda_low_q;
		n_ack    = ack_q;
		n_done   = 1'b0;
		go       = 1'b0;
		tgt      = PH_FIN;

		// launch a command, count down, or move to the following segment
		if (phase_q == PH_IDLE) begin
			unique case (op) inside
				i2cbm_pkg::OP_START: begin
					n_op = op;
					go   = 1'b1;
					tgt  = PH_ST0;
				end
				i2cbm_pkg::OP_STOP: begin
					n_op = op;
					go   = 1'b1;
					tgt  = PH_SP0;
				end
				i2cbm_pkg::OP_WRITE: begin
					n_op    = op;
					n_shift = wr_byte;
					n_bit   = '0;
					go      = 1'b1;
					tgt     = PH_WB;
				end
				i2cbm_pkg::OP_READ_ACK, i2cbm_pkg::OP_READ_NACK: begin
					n_op    = op;
					n_shift = '0;
					n_bit   = '0;
					go      = 1'b1;
					tgt     = PH_R0;
				end
				default: ;
			endcase
		end else if (delay_q > 16'd1) begin
			n_delay = delay_q - 16'd1;
		end else if (second_q) begin
			n_second = 1'b0;
			n_delay  = half;
		end else begin
			go = 1'b1;
			unique case (phase_q)
				PH_ST0: tgt = PH_ST1;
				PH_ST1: tgt = PH_ST2;
				PH_SP0: tgt = PH_SP1;
				PH_SP1: tgt = PH_SP2;
				PH_WB:  tgt = PH_W1;
				PH_W1:  tgt = PH_W2;
				PH_W2:  tgt = PH_W3;
				PH_W3: begin
					n_shift = {shift_q[6:0], 1'b0};
					n_bit   = bit_q + 1'b1;
					tgt     = (n_bit < i2cbm_pkg::BIT_CNT_W'(i2cbm_pkg::BITS_PER_BYTE)) ?
						PH_WB : PH_A0;
				end
				PH_A0:  tgt = PH_A1;
				PH_A1:  tgt = PH_A2;
				PH_A2:  tgt = PH_A3;
				PH_A3:  tgt = PH_A3;
				PH_R0:  tgt = PH_R1;
				PH_R1:  tgt = PH_R2;
				PH_R2: begin
					n_bit = bit_q + 1'b1;
					tgt   = (n_bit < i2cbm_pkg::BIT_CNT_W'(i2cbm_pkg::BITS_PER_BYTE)) ?
						PH_R1 : PH_R3;
				end
				PH_K0:  tgt = PH_K1;
				PH_K1:  tgt = PH_K2;
				PH_K2:  tgt = PH_K3;
				PH_N0:  tgt = PH_N1;
				PH_N1:  tgt = PH_N2;
				default: tgt = PH_FIN;
			endcase
		end

		// enter the segment: set the pins and load the wait
		if (go) begin
			n_phase  = tgt;
			n_delay  = half;
			n_second = 1'b1;
			unique case (tgt)
				PH_ST0: begin
					n_scl = 1'b1;
					n_sda = 1'b0;
				end
				PH_ST1: n_sda = 1'b1;
				PH_ST2: n_scl = 1'b0;
				PH_SP0: begin
					n_scl = 1'b0;
					n_sda = 1'b1;
				end
				PH_SP1: n_scl = 1'b1;
				PH_SP2: n_sda = 1'b0;
				PH_WB: begin
					n_scl    = 1'b0;
					n_second = 1'b0;
				end
				PH_W1: begin
					n_sda    = ~n_shift[7];
					n_second = 1'b0;
				end
				PH_W2: n_scl = 1'b1;
				PH_W3: n_scl = 1'b0;
				PH_A0: n_sda = 1'b0;
				PH_A1: n_scl = 1'b0;
				PH_A2: begin
					n_scl  = 1'b1;
					n_poll = (cfg.ack_poll_limit == 8'd0) ? 8'd1 : cfg.ack_poll_limit;
				end
				PH_A3: begin
					// sample for ACK, give up when the poll budget runs out
					if (!sda_in) begin
						n_phase = PH_A4;
						n_scl   = 1'b0;
						n_ack   = 1'b1;
					end else if (poll_dec == 8'd0) begin
						n_poll   = poll_dec;
						n_scl    = 1'b0;
						n_ack    = 1'b0;
						n_phase  = PH_IDLE;
						n_done   = 1'b1;
						n_delay  = delay_q;
						n_second = second_q;
					end else begin
						n_poll = poll_dec;
					end
				end
				PH_R0: begin
					n_sda = 1'b0;
					if (cfg.rx_settle_ticks == 16'd0) begin
						n_phase = PH_R1;
						n_scl   = 1'b0;
					end else begin
						n_delay  = cfg.rx_settle_ticks;
						n_second = 1'b0;
					end
				end
				PH_R1: n_scl = 1'b0;
				PH_R2: begin
					n_scl   = 1'b1;
					n_shift = {n_shift[6:0], sda_in};
				end
				PH_R3: begin
					// answer ACK or NACK after the eighth bit
					n_scl = 1'b0;
					if (n_op == i2cbm_pkg::OP_READ_ACK) begin
						n_phase = PH_K0;
					end else begin
						n_phase = PH_N0;
						n_sda   = 1'b0;
					end
				end
				PH_K0: n_scl = 1'b0;
				PH_K1: n_sda = 1'b1;
				PH_K2: n_scl = 1'b1;
				PH_K3: n_scl = 1'b0;
				PH_N0: n_sda = 1'b0;
				PH_N1: n_scl = 1'b1;
				PH_N2: n_scl = 1'b0;
				default: begin
					// command finished
					n_phase  = PH_IDLE;
					n_done   = 1'b1;
					n_delay  = delay_q;
					n_second = second_q;
				end
			endcase
		end
	end

	// sequencer state, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			delay_q   <= '0;
			second_q  <= 1'b0;
			bit_q     <= '0;
			shift_q   <= '0;
			poll_q    <= '0;
			op_q      <= i2cbm_pkg::OP_TICK;
			scl_q     <= 1'b1;
			sda_low_q <= 1'b0;
			ack_q     <= 1'b0;
		end else if (en) begin
			phase_q   <= n_phase;
			delay_q   <= n_delay;
			second_q  <= n_second;
			bit_q     <= n_bit;
			shift_q   <= n_shift;
			poll_q    <= n_poll;
			op_q      <= n_op;
			scl_q     <= n_scl;
			sda_low_q <= n_sda;
			ack_q     <= n_ack;
		end
	end

	// result of this tick
	always_comb begin
		res.scl_high = n_scl;
		res.sda_low  = n_sda;
		res.busy_res = (n_phase != PH_IDLE);
		res.done_res = n_done;
		res.ack_ok   = n_done && (n_op == i2cbm_pkg::OP_WRITE) && n_ack;
		res.rd_byte  = (n_done && (n_op == i2cbm_pkg::OP_READ_ACK ||
			n_op == i2cbm_pkg::OP_READ_NACK)) ? n_shift : 8'd0;
	end

endmodule
